### sv/fke_pkg.sv
`default_nettype none

package fke_pkg;

    localparam int MID_DEPTH = 4;
    localparam int CFG_IDX_W = 1;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [7:0]  IHL_MASK       = 8'h0f;
    localparam logic [15:0] POS_MAX        = 16'hffff;

    localparam logic [15:0] POS_ETHER_HI   = 16'd12;
    localparam logic [15:0] POS_ETHER_LO   = 16'd13;
    localparam logic [15:0] POS_IHL        = 16'd14;
    localparam logic [15:0] POS_PROTO      = 16'd23;
    localparam logic [15:0] POS_SADDR_LO   = 16'd26;
    localparam logic [15:0] POS_SADDR_HI   = 16'd29;
    localparam logic [15:0] POS_DADDR_LO   = 16'd30;
    localparam logic [15:0] POS_DADDR_HI   = 16'd33;
    localparam logic [15:0] LEN_MIN_ETH    = 16'd14;
    localparam logic [15:0] LEN_MIN_IP     = 16'd24;
    localparam logic [3:0]  IHL_MIN        = 4'd5;

    localparam logic [CFG_IDX_W-1:0] REG_LOCAL_PREFIX = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_LOCAL_MASK   = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_IPV4  = 2'd1,
        ST_NOT_L4    = 2'd2,
        ST_MALFORMED = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [7:0]  ip_proto;
        logic [31:0] local_addr;
        logic [31:0] remote_addr;
        logic [15:0] near_port;
        logic [15:0] far_port;
        logic        inbound;
        logic [15:0] frame_length;
    } t_out_item;

    typedef struct packed {
        logic [15:0] frame_length;
        logic [15:0] ether_type;
        logic [3:0]  header_words;
        logic [7:0]  proto_number;
        logic [31:0] source_addr;
        logic [31:0] dest_addr;
        logic [15:0] source_port;
        logic [15:0] dest_port;
    } t_raw_key;

endpackage

`default_nettype wire

### sv/fke_parser.sv
`default_nettype none

module fke_parser (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire fke_pkg::t_in_item i_item,
    output logic                   o_raw_push,
    output fke_pkg::t_raw_key      o_raw
);

    logic [15:0] r_pos, n_pos;
    logic [15:0] r_ether, n_ether;
    logic [3:0]  r_hw, n_hw;
    logic [7:0]  r_proto, n_proto;
    logic [31:0] r_saddr, n_saddr;
    logic [31:0] r_daddr, n_daddr;
    logic [15:0] r_sport, n_sport;
    logic [15:0] r_dport, n_dport;

    logic [6:0]  pbase;
    logic [6:0]  pend;
    logic [7:0]  b;

    always_comb begin
        n_pos   = r_pos;
        n_ether = r_ether;
        n_hw    = r_hw;
        n_proto = r_proto;
        n_saddr = r_saddr;
        n_daddr = r_daddr;
        n_sport = r_sport;
        n_dport = r_dport;
        b       = i_item.data_byte;
        pbase   = 7'd14 + {1'b0, r_hw, 2'b00};
        pend    = pbase + 7'd4;
        if (i_accept && r_pos != fke_pkg::POS_MAX) begin
            n_pos = r_pos + 16'd1;
            if (r_pos == fke_pkg::POS_ETHER_HI || r_pos == fke_pkg::POS_ETHER_LO) begin
                n_ether = {r_ether[7:0], b};
            end else if (r_pos == fke_pkg::POS_IHL) begin
                n_hw = 4'(b & fke_pkg::IHL_MASK);
            end else if (r_pos == fke_pkg::POS_PROTO) begin
                n_proto = b;
            end else if (r_pos >= fke_pkg::POS_SADDR_LO && r_pos <= fke_pkg::POS_SADDR_HI) begin
                n_saddr = {r_saddr[23:0], b};
            end else if (r_pos >= fke_pkg::POS_DADDR_LO && r_pos <= fke_pkg::POS_DADDR_HI) begin
                n_daddr = {r_daddr[23:0], b};
            end
            // ports only after the header length byte
            if (r_pos > fke_pkg::POS_IHL && r_pos >= {9'd0, pbase}
                && r_pos < {9'd0, pend}) begin
                if (r_pos < {9'd0, pbase + 7'd2}) begin
                    n_sport = {r_sport[7:0], b};
                end else begin
                    n_dport = {r_dport[7:0], b};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_item.last_byte)) begin
            r_pos   <= '0;
            r_ether <= '0;
            r_hw    <= '0;
            r_proto <= '0;
            r_saddr <= '0;
            r_daddr <= '0;
            r_sport <= '0;
            r_dport <= '0;
        end else begin
            r_pos   <= n_pos;
            r_ether <= n_ether;
            r_hw    <= n_hw;
            r_proto <= n_proto;
            r_saddr <= n_saddr;
            r_daddr <= n_daddr;
            r_sport <= n_sport;
            r_dport <= n_dport;
        end
    end

    assign o_raw_push          = i_accept && i_item.last_byte;
    assign o_raw.frame_length  = n_pos;
    assign o_raw.ether_type    = n_ether;
    assign o_raw.header_words  = n_hw;
    assign o_raw.proto_number  = n_proto;
    assign o_raw.source_addr   = n_saddr;
    assign o_raw.dest_addr     = n_daddr;
    assign o_raw.source_port   = n_sport;
    assign o_raw.dest_port     = n_dport;

endmodule

`default_nettype wire

### sv/fke_fifo.sv
`default_nettype none

module fke_fifo #(
    parameter int DEPTH = fke_pkg::MID_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire fke_pkg::t_raw_key i_data,
    output logic                   o_full,
    input  wire logic              i_pop,
    output fke_pkg::t_raw_key      o_data,
    output logic                   o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    fke_pkg::t_raw_key r_mem [DEPTH];
    fke_pkg::t_raw_key r_head;
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [AW-1:0] rd_nxt;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign rd_nxt  = !do_pop ? r_rd_ptr
                   : (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
    assign o_data  = r_head;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
        // head register follows the entry at the next read pointer
        if (do_push && r_wr_ptr == rd_nxt) begin
            r_head <= i_data;
        end else begin
            r_head <= r_mem[rd_nxt];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= rd_nxt;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

### sv/fke_keygen.sv
`default_nettype none

module fke_keygen (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [fke_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]                   i_cfg_data,
    input  wire logic                          i_raw_valid,
    input  wire fke_pkg::t_raw_key             i_raw,
    output logic                               o_raw_pop,
    output logic                               o_valid,
    output fke_pkg::t_out_item                 o_key,
    input  wire logic                          i_pop
);

    logic [31:0]        r_prefix, r_mask;
    logic               r_valid;
    fke_pkg::t_out_item r_key, n_key;
    logic [6:0]         pend;
    logic               take;
    fke_pkg::t_status   st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix <= '0;
            r_mask   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                fke_pkg::REG_LOCAL_PREFIX: r_prefix <= i_cfg_data;
                fke_pkg::REG_LOCAL_MASK:   r_mask   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign take      = i_raw_valid && (!r_valid || i_pop);
    assign o_raw_pop = take;

    always_comb begin
        pend = 7'd18 + {1'b0, i_raw.header_words, 2'b00};
        if (i_raw.frame_length < fke_pkg::LEN_MIN_ETH) begin
            st = fke_pkg::ST_MALFORMED;
        end else if (i_raw.ether_type != fke_pkg::ETHERTYPE_IPV4) begin
            st = fke_pkg::ST_NOT_IPV4;
        end else if (i_raw.frame_length < fke_pkg::LEN_MIN_IP
                     || i_raw.header_words < fke_pkg::IHL_MIN) begin
            st = fke_pkg::ST_MALFORMED;
        end else if (i_raw.proto_number != fke_pkg::PROTO_TCP
                     && i_raw.proto_number != fke_pkg::PROTO_UDP) begin
            st = fke_pkg::ST_NOT_L4;
        end else if (i_raw.frame_length < {9'd0, pend}) begin
            st = fke_pkg::ST_MALFORMED;
        end else begin
            st = fke_pkg::ST_OK;
        end

        n_key              = '0;
        n_key.status       = st;
        n_key.frame_length = i_raw.frame_length;
        if (st == fke_pkg::ST_OK || st == fke_pkg::ST_NOT_L4) begin
            n_key.ip_proto = i_raw.proto_number;
        end
        if (st == fke_pkg::ST_OK) begin
            if ((i_raw.source_addr & r_mask) == (r_prefix & r_mask)) begin
                n_key.local_addr  = i_raw.source_addr;
                n_key.remote_addr = i_raw.dest_addr;
                n_key.near_port   = i_raw.source_port;
                n_key.far_port    = i_raw.dest_port;
                n_key.inbound     = 1'b0;
            end else begin
                n_key.local_addr  = i_raw.dest_addr;
                n_key.remote_addr = i_raw.source_addr;
                n_key.near_port   = i_raw.dest_port;
                n_key.far_port    = i_raw.source_port;
                n_key.inbound     = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_key <= n_key;
        end
    end

    assign o_valid = r_valid;
    assign o_key   = r_key;

endmodule

`default_nettype wire

### sv/flow_key_extractor_core.sv
// flow key extractor: pulls an IPv4 five-tuple flow key out of Ethernet frames
// input queue side: one frame byte per transaction (push while full is low),
// last_byte set on the final captured byte of a frame
// result queue side: one flow key per frame; the key is on o_result while
// empty is low and is taken with pop
// config channel: cfg_valid/cfg_ready write local_prefix (index 0) and
// local_mask (index 1); cfg_ready is always high, write only while idle
// throughput: one byte per cycle while full is low, frames back to back with no gap
// the frame's fields are written into the frame queue when its last byte is taken;
// the key stage then registers the key from the queue head once its output is free
// a small frame queue sits between parser and key stage; when the receiver
// stalls, finished keys pile up there and full rises only once it holds
// MID_DEPTH keys and the output register is occupied
// reset clears the byte counter, captured fields, queues and both registers
`default_nettype none

module flow_key_extractor_core #(
    parameter int MID_DEPTH = fke_pkg::MID_DEPTH
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire fke_pkg::t_in_item             i_item,
    output logic                               empty,
    input  wire logic                          pop,
    output fke_pkg::t_out_item                 o_result,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [fke_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]                   i_cfg_data
);

    logic              in_accept;
    logic              raw_push, raw_pop, mid_full, mid_empty;
    logic              key_valid;
    fke_pkg::t_raw_key raw_in, raw_out;

    assign o_cfg_ready = 1'b1;
    assign full        = mid_full;
    assign in_accept   = push && !mid_full;

    fke_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (in_accept),
        .i_item     (i_item),
        .o_raw_push (raw_push),
        .o_raw      (raw_in)
    );

    fke_fifo #(
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (raw_push),
        .i_data  (raw_in),
        .o_full  (mid_full),
        .i_pop   (raw_pop),
        .o_data  (raw_out),
        .o_empty (mid_empty)
    );

    fke_keygen u_keygen (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_raw_valid (!mid_empty),
        .i_raw       (raw_out),
        .o_raw_pop   (raw_pop),
        .o_valid     (key_valid),
        .o_key       (o_result),
        .i_pop       (pop)
    );

    assign empty = !key_valid;

endmodule

`default_nettype wire
